FILE: rtl/pse_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the postfix stack evaluator.
// No dependencies.
package pse_pkg;

    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int CMDQ_DEPTH      = 4;

    localparam logic [1:0] REQ_NUM = 2'd0;
    localparam logic [1:0] REQ_OP  = 2'd1;
    localparam logic [1:0] REQ_END = 2'd2;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_OP   = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_TOO_MANY_OPS  = 3'd1;
    localparam logic [2:0] ST_TOO_MANY_NUMS = 3'd2;
    localparam logic [2:0] ST_OVERFLOW      = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO      = 3'd4;
    localparam logic [2:0] ST_EMPTY         = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [30:0] number_value;
        logic [1:0]  operator_code;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic               expr_done;
    } t_rsp;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] number;
        logic [1:0]  op;
    } t_cmd;

    typedef struct packed {
        logic                      start;
        logic signed [DATA_W-1:0] dividend;
        logic signed [DATA_W-1:0] divisor;
    } t_div_req;

endpackage

FILE: rtl/postfix_stack_evaluator_top.sv
`timescale 1ns / 1ps
// Postfix stack evaluator, top level. Depends on pse_pkg, pse_front,
// pse_cmd_queue and pse_back.
//
// Usage:
//   Request channel: drive i_req and raise push; the transaction is taken at
//   a rising edge with push high and full low. Request code 3 is taken and
//   discarded without a result.
//   Result channel: while empty is low, o_rsp holds the oldest result; it
//   is taken at a rising edge with pop high. One result per number,
//   operator or end request, in request order.
//   A request passes through the command queue, is taken by the back end
//   with its operands read from the stack, and is executed into the result
//   register; a divide first waits for the one-bit-per-cycle divider.
//   The back end takes one command at a time, and only while the result register is free or being popped.
//   A 4-entry command queue keeps taking requests while the back end works
//   or while the result register waits; when the receiver stalls, the back
//   end holds its result and full rises once the queue fills.
//   Reset (synchronous, active low) empties the queue, the result register
//   and the operand stack; stack memory contents are not cleared.
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  pse_pkg::t_req i_req,
    output logic          empty,
    input  logic          pop,
    output pse_pkg::t_rsp o_rsp
);

    logic          q_full;
    logic          q_empty;
    logic          q_wr;
    logic          q_rd;
    pse_pkg::t_cmd wr_cmd;
    pse_pkg::t_cmd rd_cmd;

    pse_front u_front (
        .push     (push),
        .i_req    (i_req),
        .i_q_full (q_full),
        .full     (full),
        .o_wr     (q_wr),
        .o_cmd    (wr_cmd)
    );

    pse_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (wr_cmd),
        .i_rd    (q_rd),
        .o_cmd   (rd_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pse_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (rd_cmd),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .o_rsp     (o_rsp),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

FILE: rtl/pse_front.sv
`timescale 1ns / 1ps
// Front end: accepts request transactions, classifies them into commands
// and drops unused request codes. Depends on pse_pkg.
module pse_front (
    input  logic          push,
    input  pse_pkg::t_req i_req,
    input  logic          i_q_full,
    output logic          full,
    output logic          o_wr,
    output pse_pkg::t_cmd o_cmd
);

    logic known;

    always_comb begin
        known        = 1'b1;
        o_cmd.kind   = pse_pkg::CMD_PUSH;
        o_cmd.number = i_req.number_value;
        o_cmd.op     = i_req.operator_code;
        unique case (i_req.req_type)
            pse_pkg::REQ_NUM: o_cmd.kind = pse_pkg::CMD_PUSH;
            pse_pkg::REQ_OP:  o_cmd.kind = pse_pkg::CMD_OP;
            pse_pkg::REQ_END: o_cmd.kind = pse_pkg::CMD_END;
            default:          known      = 1'b0;
        endcase
    end

    assign full = i_q_full;
    assign o_wr = push && !i_q_full && known;

endmodule

FILE: rtl/pse_cmd_queue.sv
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on pse_pkg; depth is a power of two.
module pse_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  pse_pkg::t_cmd i_cmd,
    input  logic          i_rd,
    output pse_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = $clog2(pse_pkg::CMDQ_DEPTH);

    pse_pkg::t_cmd r_q [pse_pkg::CMDQ_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_wr ? r_wp + PW'(1) : r_wp;
        n_rp  = i_rd ? r_rp + PW'(1) : r_rp;
        n_cnt = r_cnt + (PW + 1)'(i_wr) - (PW + 1)'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    assign o_cmd   = r_q[r_rp];
    assign o_full  = (r_cnt == (PW + 1)'(pse_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

FILE: rtl/pse_div.sv
`timescale 1ns / 1ps
// Signed truncating divider, one quotient bit per cycle (restoring).
// Depends on pse_pkg.
module pse_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pse_pkg::t_div_req              i_req,
    output logic                           o_done,
    output logic signed [pse_pkg::DATA_W-1:0] o_quotient
);

    localparam int W  = pse_pkg::DATA_W;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_mag_d;
    logic          r_neg;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          q_bit;
    logic [W-1:0]  step_rem;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;

    always_comb begin
        mag_a    = i_req.dividend[W-1] ? W'(-i_req.dividend) : W'(i_req.dividend);
        mag_b    = i_req.divisor[W-1]  ? W'(-i_req.divisor)  : W'(i_req.divisor);
        rem_sh   = {r_rem, r_quo[W-1]};
        diff     = rem_sh - {1'b0, r_mag_d};
        q_bit    = !diff[W];
        step_rem = q_bit ? diff[W-1:0] : rem_sh[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt   <= '0;
            r_quo   <= mag_a;
            r_rem   <= '0;
            r_mag_d <= mag_b;
            r_neg   <= i_req.dividend[W-1] ^ i_req.divisor[W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_quo <= {r_quo[W-2:0], q_bit};
            r_rem <= step_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

FILE: rtl/pse_back.sv
`timescale 1ns / 1ps
// Back end: operand stack memory, arithmetic, divider control and the
// result register. Depends on pse_pkg and pse_div.
module pse_back #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pse_pkg::t_cmd i_cmd,
    input  logic          i_q_empty,
    output logic          o_q_rd,
    output pse_pkg::t_rsp o_rsp,
    output logic          empty,
    input  logic          pop
);

    localparam int W  = pse_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_out_valid, n_out_valid;
    pse_pkg::t_rsp       r_out, n_out;
    pse_pkg::t_cmd       r_cmd;
    logic [W-1:0]        r_mem [STACK_DEPTH];
    logic [W-1:0]        r_rd_top;
    logic [W-1:0]        r_rd_next;

    logic                pop_fire;
    logic                cmd_take;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [W-1:0]        mem_wdata;
    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       cnt_m2;
    logic [W-1:0]        prod;
    pse_pkg::t_div_req   div_req;
    logic                div_done;
    logic signed [W-1:0] div_q;

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign pop_fire = pop && r_out_valid;
    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign prod     = r_rd_next * r_rd_top;

    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_out_valid      = r_out_valid && !pop_fire;
        n_out            = r_out;
        cmd_take         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = cnt_m2[AW-1:0];
        mem_wdata        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = $signed(r_rd_next);
        div_req.divisor  = $signed(r_rd_top);
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty && (!r_out_valid || pop_fire)) begin
                    cmd_take = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state           = S_IDLE;
                n_out_valid       = 1'b1;
                n_out.status      = pse_pkg::ST_OK;
                n_out.value       = '0;
                n_out.expr_done   = 1'b0;
                unique case (r_cmd.kind)
                    pse_pkg::CMD_PUSH: begin
                        if (r_count == CW'(STACK_DEPTH)) begin
                            n_out.status = pse_pkg::ST_OVERFLOW;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = {1'b0, r_cmd.number};
                            n_count   = r_count + CW'(1);
                        end
                    end
                    pse_pkg::CMD_OP: begin
                        if (r_count < CW'(2)) begin
                            n_count      = '0;
                            n_out.status = pse_pkg::ST_TOO_MANY_OPS;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = cnt_m1;
                            unique case (r_cmd.op)
                                pse_pkg::OP_ADD: mem_wdata = r_rd_next + r_rd_top;
                                pse_pkg::OP_SUB: mem_wdata = r_rd_next - r_rd_top;
                                pse_pkg::OP_MUL: mem_wdata = prod;
                                pse_pkg::OP_DIV: begin
                                    if (r_rd_top == '0) begin
                                        n_out.status = pse_pkg::ST_DIV_ZERO;
                                    end else begin
                                        mem_we        = 1'b0;
                                        n_count       = r_count;
                                        n_out_valid   = 1'b0;
                                        div_req.start = 1'b1;
                                        n_state       = S_DIV;
                                    end
                                end
                                default: mem_wdata = '0;
                            endcase
                            if (r_cmd.op != pse_pkg::OP_DIV) begin
                                n_out.value = $signed(mem_wdata);
                            end
                        end
                    end
                    pse_pkg::CMD_END: begin
                        n_count         = '0;
                        n_out.expr_done = 1'b1;
                        if (r_count == '0) begin
                            n_out.status = pse_pkg::ST_EMPTY;
                        end else if (r_count == CW'(1)) begin
                            n_out.value = $signed(r_rd_top);
                        end else begin
                            n_out.status = pse_pkg::ST_TOO_MANY_NUMS;
                        end
                    end
                    default: n_out_valid = r_out_valid;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    mem_we          = 1'b1;
                    mem_wdata       = div_q;
                    n_count         = cnt_m1;
                    n_out_valid     = 1'b1;
                    n_out.status    = pse_pkg::ST_OK;
                    n_out.value     = div_q;
                    n_out.expr_done = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (cmd_take) begin
            r_cmd     <= i_cmd;
            r_rd_top  <= r_mem[cnt_m1[AW-1:0]];
            r_rd_next <= r_mem[cnt_m2[AW-1:0]];
        end
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    assign o_q_rd = cmd_take;
    assign o_rsp  = r_out;
    assign empty  = !r_out_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("operand count beyond stack depth");

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> !r_out_valid)
        else $error("command executing while result register is occupied");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide wait");

    a_div_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> r_state == S_DIV && !r_out_valid)
        else $error("divide start without divide wait");

endmodule

FILE: verif/pse_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the postfix stack evaluator: watches both queue ports,
// keeps its own operand stack and compares every popped result in order.
// Depends on pse_pkg.
module pse_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  pse_pkg::t_req i_req,
    input  logic          i_empty,
    input  logic          i_pop,
    input  pse_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending
);

    localparam int DEPTH = pse_pkg::STACK_DEPTH_DEF;

    logic [31:0]   operands [DEPTH];
    int            used_entries;
    pse_pkg::t_rsp expected_results [$];
    int            mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_results.size();

    task automatic report(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [31:0] trunc_quotient(input logic [31:0] num,
                                                   input logic [31:0] den);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] q;
        mag_n = num[31] ? (32'd0 - num) : num;
        mag_d = den[31] ? (32'd0 - den) : den;
        q     = mag_n / mag_d;
        return (num[31] != den[31]) ? (32'd0 - q) : q;
    endfunction

    task automatic evaluate_request(input pse_pkg::t_req r);
        pse_pkg::t_rsp res;
        logic [31:0]   lhs;
        logic [31:0]   rhs;
        logic [31:0]   acc;
        res = '0;
        case (r.req_type)
            pse_pkg::REQ_NUM: begin
                if (used_entries >= DEPTH) begin
                    res.status = pse_pkg::ST_OVERFLOW;
                end else begin
                    operands[used_entries] = {1'b0, r.number_value};
                    used_entries++;
                    res.status = pse_pkg::ST_OK;
                end
                expected_results.push_back(res);
            end
            pse_pkg::REQ_OP: begin
                if (used_entries < 2) begin
                    used_entries = 0;
                    res.status   = pse_pkg::ST_TOO_MANY_OPS;
                end else begin
                    rhs = operands[used_entries - 1];
                    lhs = operands[used_entries - 2];
                    used_entries -= 2;
                    case (r.operator_code)
                        pse_pkg::OP_ADD: acc = lhs + rhs;
                        pse_pkg::OP_SUB: acc = lhs - rhs;
                        pse_pkg::OP_MUL: acc = lhs * rhs;
                        default: acc = (rhs == 32'd0) ? 32'd0 : trunc_quotient(lhs, rhs);
                    endcase
                    operands[used_entries] = acc;
                    used_entries++;
                    if (r.operator_code == pse_pkg::OP_DIV && rhs == 32'd0) begin
                        res.status = pse_pkg::ST_DIV_ZERO;
                    end else begin
                        res.status = pse_pkg::ST_OK;
                        res.value  = acc;
                    end
                end
                expected_results.push_back(res);
            end
            pse_pkg::REQ_END: begin
                res.expr_done = 1'b1;
                if (used_entries == 0) begin
                    res.status = pse_pkg::ST_EMPTY;
                end else if (used_entries == 1) begin
                    res.status = pse_pkg::ST_OK;
                    res.value  = operands[0];
                end else begin
                    res.status = pse_pkg::ST_TOO_MANY_NUMS;
                end
                used_entries = 0;
                expected_results.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        pse_pkg::t_rsp want;
        if (!i_rst_n) begin
            used_entries = 0;
            expected_results.delete();
        end else begin
            if (i_push && !i_full) begin
                evaluate_request(i_req);
            end
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    report($sformatf("unexpected result, status %0d value %0d",
                                     i_rsp.status, i_rsp.value));
                end else begin
                    want = expected_results.pop_front();
                    if (i_rsp.status !== want.status)
                        report($sformatf("status: expected %0d, got %0d",
                                         want.status, i_rsp.status));
                    if (i_rsp.value !== want.value)
                        report($sformatf("value: expected %0d, got %0d",
                                         want.value, i_rsp.value));
                    if (i_rsp.expr_done !== want.expr_done)
                        report($sformatf("expr_done: expected %0d, got %0d",
                                         want.expr_done, i_rsp.expr_done));
                end
            end
        end
    end

    initial begin
        mismatches   = 0;
        used_entries = 0;
    end

endmodule

FILE: verif/tb_postfix_stack_evaluator_top.sv
`timescale 1ns / 1ps
// Testbench top for the postfix stack evaluator: drives directed and random
// postfix token streams with random gaps and pop stalls, and gives the verdict.
// Depends on pse_pkg, postfix_stack_evaluator_top and pse_result_checker.
module tb_postfix_stack_evaluator_top;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         TARGET_ITEMS = 700;
    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         HOLD_START   = 1000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CALM_START   = 2500;
    localparam int         CALM_END     = 3300;
    localparam int         DRAIN_CYCLES = 60;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           push    = 1'b0;
    logic           pop     = 1'b0;
    pse_pkg::t_req  i_req   = '0;
    logic           full;
    logic           empty;
    pse_pkg::t_rsp  o_rsp;
    int             fail_count;
    int             pending_count;
    int             cycle_count = 0;
    int             hold_left   = 0;
    int             sent_items  = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    postfix_stack_evaluator_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_req  (i_req),
        .empty  (empty),
        .pop    (pop),
        .o_rsp  (o_rsp)
    );

    pse_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_req       (i_req),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_rsp       (o_rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    function automatic bit calm_window();
        return cycle_count >= CALM_START && cycle_count < CALM_END;
    endfunction

    // Receiver: random stalls, one long hold-off to back up the queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (cycle_count == HOLD_START) begin
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else if (calm_window()) begin
            pop <= 1'b1;
        end else begin
            pop <= ($urandom_range(0, 99) >= 32);
        end
    end

    task automatic offer_request(input pse_pkg::t_req r);
        if (!calm_window() && $urandom_range(0, 99) < 32) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (r.req_type != REQ_UNUSED)
            sent_items++;
    endtask

    task automatic push_number(input logic [30:0] v);
        pse_pkg::t_req r;
        r              = '0;
        r.req_type     = pse_pkg::REQ_NUM;
        r.number_value = v;
        r.operator_code = 2'($urandom);
        offer_request(r);
    endtask

    task automatic apply_operator(input logic [1:0] op);
        pse_pkg::t_req r;
        r               = '0;
        r.req_type      = pse_pkg::REQ_OP;
        r.number_value  = 31'($urandom);
        r.operator_code = op;
        offer_request(r);
    endtask

    task automatic end_expression();
        pse_pkg::t_req r;
        r          = '0;
        r.req_type = pse_pkg::REQ_END;
        offer_request(r);
    endtask

    function automatic logic [30:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2, 3, 4, 5: return 31'($urandom_range(0, 20));
            6, 7:    return 31'($urandom_range(0, 65535));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic random_expression();
        int operands_left;
        int depth;
        operands_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                   : $urandom_range(1, 6);
        depth = 0;
        while (operands_left > 0 || depth > 1) begin
            if (depth >= 2 && (operands_left == 0 || $urandom_range(0, 1) == 1)) begin
                apply_operator(2'($urandom_range(0, 3)));
                depth--;
            end else begin
                push_number(pick_operand());
                operands_left--;
                depth++;
            end
        end
        end_expression();
    endtask

    task automatic overflow_burst();
        repeat ($urandom_range(14, 20)) push_number(pick_operand());
        if ($urandom_range(0, 1) == 1)
            apply_operator(2'($urandom_range(0, 3)));
        end_expression();
    endtask

    task automatic noise_tokens();
        pse_pkg::t_req r;
        repeat ($urandom_range(1, 4)) begin
            r.req_type      = 2'($urandom_range(0, 3));
            r.number_value  = pick_operand();
            r.operator_code = 2'($urandom_range(0, 3));
            offer_request(r);
        end
    endtask

    initial begin
        pse_pkg::t_req odd_req;
        int            choice;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty stack, operators starved of operands.
        end_expression();
        apply_operator(pse_pkg::OP_ADD);
        push_number(31'd5);
        apply_operator(pse_pkg::OP_SUB);
        end_expression();
        // Largest operands, wrapping add and multiply.
        push_number(31'h7FFF_FFFF);
        push_number(31'h7FFF_FFFF);
        apply_operator(pse_pkg::OP_ADD);
        push_number(31'd3);
        apply_operator(pse_pkg::OP_MUL);
        end_expression();
        // Most negative value divided by minus one.
        push_number(31'h4000_0000);
        push_number(31'd2);
        apply_operator(pse_pkg::OP_MUL);
        push_number(31'd0);
        push_number(31'd1);
        apply_operator(pse_pkg::OP_SUB);
        apply_operator(pse_pkg::OP_DIV);
        end_expression();
        // Divide by zero, then too many numbers.
        push_number(31'd9);
        push_number(31'd0);
        apply_operator(pse_pkg::OP_DIV);
        end_expression();
        push_number(31'd3);
        push_number(31'd5);
        end_expression();
        // Unused request code.
        odd_req               = '0;
        odd_req.req_type      = REQ_UNUSED;
        odd_req.number_value  = 31'h7FFF_FFFF;
        odd_req.operator_code = pse_pkg::OP_DIV;
        offer_request(odd_req);

        while (sent_items < TARGET_ITEMS) begin
            choice = $urandom_range(0, 99);
            if (choice < 80)
                random_expression();
            else if (choice < 86)
                overflow_burst();
            else
                noise_tokens();
        end
        push <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: postfix_stack_evaluator_top.f
rtl/pse_pkg.sv
rtl/pse_front.sv
rtl/pse_cmd_queue.sv
rtl/pse_div.sv
rtl/pse_back.sv
rtl/postfix_stack_evaluator_top.sv
verif/pse_result_checker.sv
verif/tb_postfix_stack_evaluator_top.sv
